/* rtl/core/gmc_pkg.sv */
package gmc_pkg;

    localparam int MAX_COLS_DEFAULT   = 512;
    localparam int VALUE_BITS_DEFAULT = 32;

    localparam int MAX_ROWS   = 4096;
    localparam int ROW_W      = 12;
    localparam int ROWS_W     = 13;
    localparam int COLS_CFG_W = 10;
    localparam int CFG_DATA_W = 13;
    localparam int CFG_IDX_W  = 1;
    localparam int COUNT_W    = 22;
    localparam int BUMP_W     = 3;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_COLS = 1'b1;

    typedef struct packed {
        logic first_row;
        logic last_row;
        logic first_col;
        logic last_col;
    } pos_t;

endpackage

/* rtl/core/gmc_line_mem.sv */
module gmc_line_mem #(
    parameter int DEPTH = gmc_pkg::MAX_COLS_DEFAULT,
    parameter int WIDTH = gmc_pkg::VALUE_BITS_DEFAULT + 2
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] mem_rd_reg;
    logic [WIDTH-1:0] byp_data_reg;
    logic             byp_valid_reg;
    logic             byp_valid_next;

    // A write and a read of the same entry in one cycle return the new data.
    assign byp_valid_next = we && (waddr == raddr);

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        mem_rd_reg   <= mem[raddr];
        byp_data_reg <= wdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byp_valid_reg <= 1'b0;
        end
        else
        begin
            byp_valid_reg <= byp_valid_next;
        end
    end

    assign rdata = byp_valid_reg ? byp_data_reg : mem_rd_reg;

endmodule

/* rtl/core/gmc_frame_ctrl.sv */
module gmc_frame_ctrl #(
    parameter int MAX_COLS = gmc_pkg::MAX_COLS_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [gmc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [gmc_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            accept,
    output gmc_pkg::pos_t                   pos,
    output logic                            restart,
    output logic [$clog2(MAX_COLS)-1:0]     col,
    output logic [$clog2(MAX_COLS)-1:0]     col_ahead
);

    localparam int AW    = $clog2(MAX_COLS);
    localparam int CNT_W = $clog2(MAX_COLS + 1);

    logic [gmc_pkg::ROWS_W-1:0] rows_reg;
    logic [gmc_pkg::ROWS_W-1:0] rows_next;
    logic [CNT_W-1:0]           cols_reg;
    logic [CNT_W-1:0]           cols_next;
    logic [gmc_pkg::ROW_W-1:0]  row_reg;
    logic [gmc_pkg::ROW_W-1:0]  row_next;
    logic [AW-1:0]              col_reg;
    logic [AW-1:0]              col_next;
    logic [gmc_pkg::ROWS_W-1:0] rows_in;
    logic [CNT_W-1:0]           cols_in;
    logic [gmc_pkg::COLS_CFG_W-1:0] cols_raw;

    always_comb
    begin
        if (cfg_data == '0)
        begin
            rows_in = gmc_pkg::ROWS_W'(1);
        end
        else if (32'(cfg_data) > 32'(gmc_pkg::MAX_ROWS))
        begin
            rows_in = gmc_pkg::ROWS_W'(gmc_pkg::MAX_ROWS);
        end
        else
        begin
            rows_in = cfg_data;
        end

        cols_raw = cfg_data[gmc_pkg::COLS_CFG_W-1:0];
        if (cols_raw == '0)
        begin
            cols_in = CNT_W'(1);
        end
        else if (32'(cols_raw) > 32'(MAX_COLS))
        begin
            cols_in = CNT_W'(MAX_COLS);
        end
        else
        begin
            cols_in = CNT_W'(cols_raw);
        end
    end

    assign pos.first_row = (row_reg == '0);
    assign pos.last_row  = ({1'b0, row_reg} == rows_reg - gmc_pkg::ROWS_W'(1));
    assign pos.first_col = (col_reg == '0);
    assign pos.last_col  = (CNT_W'(col_reg) == cols_reg - CNT_W'(1));

    always_comb
    begin
        rows_next = rows_reg;
        cols_next = cols_reg;
        restart   = 1'b0;
        row_next  = row_reg;
        col_next  = col_reg;

        if (accept)
        begin
            if (pos.last_col)
            begin
                col_next = '0;
                row_next = pos.last_row ? '0 : row_reg + gmc_pkg::ROW_W'(1);
            end
            else
            begin
                col_next = col_reg + AW'(1);
            end
        end

        if (cfg_we)
        begin
            unique case (cfg_index)
                gmc_pkg::REG_GRID_ROWS:
                begin
                    rows_next = rows_in;
                    restart   = 1'b1;
                end
                gmc_pkg::REG_GRID_COLS:
                begin
                    cols_next = cols_in;
                    restart   = 1'b1;
                end
                default:
                begin
                    restart = 1'b0;
                end
            endcase
        end

        if (restart)
        begin
            row_next = '0;
            col_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg <= gmc_pkg::ROWS_W'(1);
            cols_reg <= CNT_W'(1);
            row_reg  <= '0;
            col_reg  <= '0;
        end
        else
        begin
            rows_reg <= rows_next;
            cols_reg <= cols_next;
            row_reg  <= row_next;
            col_reg  <= col_next;
        end
    end

    assign col       = col_reg;
    assign col_ahead = col_next;

endmodule

/* rtl/core/gmc_decide.sv */
module gmc_decide #(
    parameter int VALUE_BITS = gmc_pkg::VALUE_BITS_DEFAULT
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             accept,
    input  logic                             restart,
    input  gmc_pkg::pos_t                    pos,
    input  logic signed [VALUE_BITS-1:0]     cell_value,
    input  logic [VALUE_BITS+1:0]            rd_word,
    output logic [VALUE_BITS+1:0]            wr_word,
    input  logic                             count_ready,
    output logic                             count_valid,
    output logic [gmc_pkg::COUNT_W-1:0]      maxima_count,
    output logic                             cell_ready
);

    localparam int SUM_W = gmc_pkg::COUNT_W + gmc_pkg::BUMP_W;

    logic signed [VALUE_BITS-1:0] above;
    logic                         above_ok;
    logic                         above_right;
    logic                         gt_above;
    logic                         lt_above;
    logic                         gt_left;
    logic                         lt_left;
    logic                         ok;
    logic                         right_flag;
    logic                         bump_a;
    logic                         bump_b;
    logic                         bump_c;
    logic                         bump_d;
    logic [gmc_pkg::BUMP_W-1:0]   bumps;
    logic [SUM_W-1:0]             sum;
    logic [gmc_pkg::COUNT_W-1:0]  count_sat;
    logic                         frame_end;

    logic signed [VALUE_BITS-1:0] left_reg;
    logic                         left_ok_reg;
    logic                         hold_reg;
    logic [gmc_pkg::COUNT_W-1:0]  count_reg;
    logic [gmc_pkg::COUNT_W-1:0]  count_next;
    logic [gmc_pkg::COUNT_W-1:0]  result_reg;
    logic                         result_valid_reg;
    logic                         result_valid_next;

    // Each stored entry keeps the cell value, whether it beat its upper and
    // left neighbors, and whether its left neighbor beat it.
    assign above       = $signed(rd_word[VALUE_BITS-1:0]);
    assign right_flag  = rd_word[VALUE_BITS];
    assign above_ok    = rd_word[VALUE_BITS+1];
    assign above_right = right_flag;

    assign gt_above = cell_value > above;
    assign lt_above = above > cell_value;
    assign gt_left  = cell_value > left_reg;
    assign lt_left  = left_reg > cell_value;

    assign ok = (pos.first_row || gt_above) && (pos.first_col || gt_left);

    assign wr_word = {ok, pos.first_col || lt_left, cell_value};

    // The upper cell of the previous column is settled once the flag of its
    // right neighbor is read back in this column.
    assign bump_a = !pos.first_row && !pos.first_col && hold_reg && above_right;
    assign bump_b = !pos.first_row && pos.last_col && above_ok && lt_above;
    assign bump_c = pos.last_row && !pos.first_col && left_ok_reg && lt_left;
    assign bump_d = pos.last_row && pos.last_col && ok;

    assign bumps = gmc_pkg::BUMP_W'(bump_a) + gmc_pkg::BUMP_W'(bump_b)
                 + gmc_pkg::BUMP_W'(bump_c) + gmc_pkg::BUMP_W'(bump_d);
    assign sum   = SUM_W'(count_reg) + SUM_W'(bumps);
    assign count_sat = (sum > SUM_W'(gmc_pkg::COUNT_MAX)) ? gmc_pkg::COUNT_MAX
                                                          : sum[gmc_pkg::COUNT_W-1:0];

    assign frame_end  = accept && pos.last_row && pos.last_col;
    assign cell_ready = !result_valid_reg || count_ready;

    always_comb
    begin
        count_next        = count_reg;
        result_valid_next = result_valid_reg;
        if (count_ready)
        begin
            result_valid_next = 1'b0;
        end
        if (accept)
        begin
            count_next = frame_end ? '0 : count_sat;
        end
        if (frame_end)
        begin
            result_valid_next = 1'b1;
        end
        if (restart)
        begin
            count_next = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            left_reg    <= cell_value;
            left_ok_reg <= ok;
            hold_reg    <= above_ok && lt_above;
        end
        if (frame_end)
        begin
            result_reg <= count_sat;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg        <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg        <= count_next;
            result_valid_reg <= result_valid_next;
        end
    end

    assign count_valid  = result_valid_reg;
    assign maxima_count = result_reg;

endmodule

/* rtl/core/grid_local_maximum_counter.sv */
// Takes one cell per cycle while no finished count waits, with no bubbles between items or frames.
// The count of a frame shows on the output port in the cycle after its last cell is accepted.
// Cell input stalls only while a finished count waits to be taken.
// The line memory has a registered read, fetched one cell ahead with a bypass.
// Reset clears position, count and output valid; the grid size returns to 1x1.
module grid_local_maximum_counter #(
    parameter int MAX_COLS   = gmc_pkg::MAX_COLS_DEFAULT,
    parameter int VALUE_BITS = gmc_pkg::VALUE_BITS_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [gmc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [gmc_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            cell_valid,
    output logic                            cell_ready,
    input  logic signed [VALUE_BITS-1:0]    cell_value,
    output logic                            count_valid,
    input  logic                            count_ready,
    output logic [gmc_pkg::COUNT_W-1:0]     maxima_count
);

    localparam int AW = $clog2(MAX_COLS);

    gmc_pkg::pos_t         pos;
    logic                  accept;
    logic                  restart;
    logic [AW-1:0]         col;
    logic [AW-1:0]         col_ahead;
    logic [VALUE_BITS+1:0] rd_word;
    logic [VALUE_BITS+1:0] wr_word;

    assign accept = cell_valid && cell_ready;

    gmc_frame_ctrl #(
        .MAX_COLS (MAX_COLS)
    ) u_frame_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .accept    (accept),
        .pos       (pos),
        .restart   (restart),
        .col       (col),
        .col_ahead (col_ahead)
    );

    gmc_line_mem #(
        .DEPTH (MAX_COLS),
        .WIDTH (VALUE_BITS + 2)
    ) u_line_mem (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (accept),
        .waddr (col),
        .wdata (wr_word),
        .raddr (col_ahead),
        .rdata (rd_word)
    );

    gmc_decide #(
        .VALUE_BITS (VALUE_BITS)
    ) u_decide (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .restart      (restart),
        .pos          (pos),
        .cell_value   (cell_value),
        .rd_word      (rd_word),
        .wr_word      (wr_word),
        .count_ready  (count_ready),
        .count_valid  (count_valid),
        .maxima_count (maxima_count),
        .cell_ready   (cell_ready)
    );

endmodule

/* rtl/core/gmc_checker.sv */
module gmc_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        cell_valid,
    input logic                        cell_ready,
    input logic                        count_valid,
    input logic                        count_ready,
    input logic [gmc_pkg::COUNT_W-1:0] maxima_count
);

    // A count appears only after a cell transfer.
    a_count_after_cell: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(count_valid) |-> $past(cell_valid && cell_ready))
        else $error("count appeared without a cell transfer");

    // A taken count is gone unless a new frame ended in the same cycle.
    a_count_clears: assert property (@(posedge clk) disable iff (!rst_n)
        count_valid && count_ready && !(cell_valid && cell_ready) |=> !count_valid)
        else $error("count repeated after its transfer");

    // Cell input stalls only behind a waiting count.
    a_ready_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !cell_ready |-> count_valid && !count_ready)
        else $error("cell input stalled without a waiting count");

    // The count never exceeds the number of cells of the largest grid.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_valid |-> maxima_count <= gmc_pkg::COUNT_W'(2097152))
        else $error("count out of range");

    // A waiting count holds its value.
    a_count_hold: assert property (@(posedge clk) disable iff (!rst_n)
        count_valid && !count_ready |=> count_valid && $stable(maxima_count))
        else $error("waiting count changed");

endmodule

bind grid_local_maximum_counter gmc_checker u_gmc_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .cell_valid   (cell_valid),
    .cell_ready   (cell_ready),
    .count_valid  (count_valid),
    .count_ready  (count_ready),
    .maxima_count (maxima_count)
);

/* tb/sv/grid_local_maximum_counter_tb.sv */
module grid_local_maximum_counter_tb;

    localparam int VALUE_BITS     = gmc_pkg::VALUE_BITS_DEFAULT;
    localparam int MAX_COLS       = gmc_pkg::MAX_COLS_DEFAULT;
    localparam int COUNT_W        = gmc_pkg::COUNT_W;
    localparam int RANDOM_ITEMS   = 560;
    localparam int SETTLE_CYCLES  = 8;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 1000;

    localparam logic signed [VALUE_BITS-1:0] VALUE_MIN = {1'b1, {(VALUE_BITS-1){1'b0}}};
    localparam logic signed [VALUE_BITS-1:0] VALUE_MAX = {1'b0, {(VALUE_BITS-1){1'b1}}};

    logic                                clk;
    logic                                rst_n;
    logic                                cfg_we;
    logic [gmc_pkg::CFG_IDX_W-1:0]       cfg_index;
    logic [gmc_pkg::CFG_DATA_W-1:0]      cfg_data;
    logic                                cell_valid;
    logic                                cell_ready;
    logic signed [VALUE_BITS-1:0]        cell_value;
    logic                                count_valid;
    logic                                count_ready;
    logic [COUNT_W-1:0]                  maxima_count;

    logic signed [VALUE_BITS-1:0] cell_queue[$];
    logic [COUNT_W-1:0]           count_expected[$];
    logic [COUNT_W-1:0]           want_count;

    // Local copy of the grid state used to predict each frame's count.
    int unsigned                  grid_rows_set;
    int unsigned                  grid_cols_set;
    logic signed [VALUE_BITS-1:0] row_mem [0:1][0:MAX_COLS-1];
    bit                           still_peak [0:MAX_COLS-1];
    int unsigned                  pos_row;
    int unsigned                  pos_col;
    int unsigned                  peak_tally;
    logic signed [VALUE_BITS-1:0] left_cell;

    int   errors;
    int   gap_pct;
    logic no_gaps;
    logic hold_kick;
    int   hold_left;
    int   send_gap;
    int   take_gap;
    int   quiet_cycles;

    grid_local_maximum_counter u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .cell_valid   (cell_valid),
        .cell_ready   (cell_ready),
        .cell_value   (cell_value),
        .count_valid  (count_valid),
        .count_ready  (count_ready),
        .maxima_count (maxima_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic int unsigned eff_rows();
        if (grid_rows_set == 0)
            return 1;
        if (grid_rows_set > gmc_pkg::MAX_ROWS)
            return gmc_pkg::MAX_ROWS;
        return grid_rows_set;
    endfunction

    function automatic int unsigned eff_cols();
        if (grid_cols_set == 0)
            return 1;
        if (grid_cols_set > MAX_COLS)
            return MAX_COLS;
        return grid_cols_set;
    endfunction

    task automatic add_peak();
        if (peak_tally < gmc_pkg::COUNT_MAX)
            peak_tally++;
    endtask

    // A cell is settled against its upper neighbor when the one below it
    // arrives; cells of the last row are settled by their right neighbor.
    task automatic count_peaks(input logic signed [VALUE_BITS-1:0] v);
        int unsigned nr;
        int unsigned nc;
        int unsigned r;
        int unsigned c;
        int          cur;
        bit          last_row;
        bit          ok;
        nr = eff_rows();
        nc = eff_cols();
        r = (pos_row >= nr) ? nr - 1 : pos_row;
        c = (pos_col >= nc) ? nc - 1 : pos_col;
        last_row = (r == nr - 1);
        cur = r % 2;
        ok = 1'b1;
        if (r > 0)
        begin
            if (still_peak[c] && row_mem[1 - cur][c] > v)
                add_peak();
            ok = v > row_mem[1 - cur][c];
        end
        if (c > 0)
        begin
            ok = ok && (v > left_cell);
            still_peak[c - 1] = still_peak[c - 1] && (left_cell > v);
            if (last_row && still_peak[c - 1])
                add_peak();
        end
        still_peak[c] = ok;
        row_mem[cur][c] = v;
        left_cell = v;
        if (c == nc - 1)
        begin
            pos_col = 0;
            if (last_row)
            begin
                if (still_peak[c])
                    add_peak();
                count_expected.push_front(COUNT_W'(peak_tally));
                peak_tally = 0;
                pos_row = 0;
            end
            else
            begin
                pos_row = r + 1;
            end
        end
        else
        begin
            pos_col = c + 1;
            pos_row = r;
        end
    endtask

    task automatic flag_error(input string msg);
        $display("ERROR: %s", msg);
        errors++;
    endtask

    task automatic settle_block();
        @(negedge clk);
        while (cell_queue.size() != 0 || cell_valid || count_expected.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Writes both size registers; either write restarts the frame.
    task automatic set_grid(input logic [gmc_pkg::CFG_DATA_W-1:0] rows,
                            input logic [gmc_pkg::CFG_DATA_W-1:0] cols);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= gmc_pkg::REG_GRID_ROWS;
        cfg_data  <= rows;
        @(posedge clk);
        cfg_index <= gmc_pkg::REG_GRID_COLS;
        cfg_data  <= cols;
        @(posedge clk);
        cfg_we <= 1'b0;
        grid_rows_set = rows;
        grid_cols_set = cols[gmc_pkg::COLS_CFG_W-1:0];
        pos_row = 0;
        pos_col = 0;
        peak_tally = 0;
    endtask

    function automatic logic signed [VALUE_BITS-1:0] draw_value(input int spread);
        case (spread)
            0: return $urandom;
            1: return $signed($urandom_range(6)) - 3;
            default:
                case ($urandom_range(4))
                    0: return VALUE_MIN;
                    1: return VALUE_MAX;
                    2: return '0;
                    3: return '1;
                    default: return $urandom;
                endcase
        endcase
    endfunction

    task automatic load_cells(input int unsigned n, input int spread);
        repeat (n) cell_queue.push_front(draw_value(spread));
    endtask

    // Sender: one item per transfer, with random bursts of idle cycles.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cell_valid <= 1'b0;
            cell_value <= '0;
            send_gap   <= 0;
        end
        else
        begin
            if (cell_valid && cell_ready)
                count_peaks(cell_value);
            if (!cell_valid || cell_ready)
            begin
                if (send_gap != 0)
                begin
                    cell_valid <= 1'b0;
                    send_gap   <= send_gap - 1;
                end
                else if (cell_queue.size() == 0)
                begin
                    cell_valid <= 1'b0;
                end
                else if (!no_gaps && hold_left == 0 && $urandom_range(99) < gap_pct)
                begin
                    cell_valid <= 1'b0;
                    send_gap   <= $urandom_range(15);
                end
                else
                begin
                    cell_valid <= 1'b1;
                    cell_value <= cell_queue.pop_back();
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hold_left <= 0;
        else if (hold_kick)
            hold_left <= HOLD_CYCLES;
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    // Receiver: checks every count transfer against the oldest prediction.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_ready <= 1'b0;
            take_gap    <= 0;
        end
        else
        begin
            if (count_valid && count_ready)
            begin
                if (count_expected.size() == 0)
                begin
                    flag_error($sformatf("maxima_count %0d with no frame pending",
                                         maxima_count));
                end
                else
                begin
                    want_count = count_expected.pop_back();
                    if (maxima_count !== want_count)
                        flag_error($sformatf("maxima_count %0d, expected %0d",
                                             maxima_count, want_count));
                end
            end
            if (hold_left != 0)
            begin
                count_ready <= 1'b0;
            end
            else if (take_gap != 0)
            begin
                count_ready <= 1'b0;
                take_gap    <= take_gap - 1;
            end
            else if (!no_gaps && $urandom_range(99) < gap_pct)
            begin
                count_ready <= 1'b0;
                take_gap    <= $urandom_range(15);
            end
            else
            begin
                count_ready <= 1'b1;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quiet_cycles <= 0;
        end
        else if ((cell_valid && cell_ready) || (count_valid && count_ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("timeout: no transfer for %0d cycles", WATCHDOG_LIMIT);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        int unsigned rows;
        int unsigned cols;
        int unsigned frames;
        int unsigned n;
        int          spread;
        int          random_items;

        rst_n     <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_index <= gmc_pkg::REG_GRID_ROWS;
        cfg_data  <= '0;
        hold_kick <= 1'b0;
        no_gaps   <= 1'b0;
        gap_pct   <= 20;
        errors        = 0;
        grid_rows_set = 1;
        grid_cols_set = 1;
        pos_row       = 0;
        pos_col       = 0;
        peak_tally    = 0;
        left_cell     = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // The reset size is 1x1, so every single cell is a maximum.
        cell_queue.push_front(VALUE_MIN);
        cell_queue.push_front(VALUE_MAX);

        // Sizes written as zero act as one.
        settle_block();
        set_grid(0, 0);
        cell_queue.push_front(-1);

        // A plateau has no strict maximum.
        settle_block();
        set_grid(2, 2);
        repeat (4) cell_queue.push_front(5);

        settle_block();
        set_grid(3, 3);
        for (int i = 0; i < 9; i++)
            cell_queue.push_front((i == 4) ? VALUE_MAX : VALUE_MIN);

        // A register write in the middle of a frame throws the partial frame away.
        settle_block();
        set_grid(2, 2);
        load_cells(3, 0);
        settle_block();
        set_grid(2, 2);
        for (int i = 1; i <= 4; i++)
            cell_queue.push_front(i);

        // Back-pressure: stall the count side long enough to block the input.
        settle_block();
        set_grid(1, 1);
        load_cells(60, 2);
        @(posedge clk);
        hold_kick <= 1'b1;
        @(posedge clk);
        hold_kick <= 1'b0;

        // The column size keeps only its low ten bits.
        settle_block();
        set_grid(2, 13'h1002);
        load_cells(4, 2);

        random_items = 0;
        while (random_items < RANDOM_ITEMS)
        begin
            rows   = ($urandom_range(9) == 0) ? $urandom_range(12, 7) : $urandom_range(6, 1);
            cols   = ($urandom_range(9) == 0) ? $urandom_range(24, 11) : $urandom_range(10, 1);
            frames = $urandom_range(3, 1);
            while (frames > 1 && random_items + frames * rows * cols > RANDOM_ITEMS)
                frames--;
            spread = $urandom_range(2);
            settle_block();
            if (random_items >= RANDOM_ITEMS - 90)
                no_gaps <= 1'b1;
            else
                case ($urandom_range(3))
                    0: gap_pct <= 0;
                    1: gap_pct <= 10;
                    2: gap_pct <= 35;
                    default: gap_pct <= 70;
                endcase
            set_grid(gmc_pkg::CFG_DATA_W'(rows), gmc_pkg::CFG_DATA_W'(cols));
            n = frames * rows * cols;
            if (!no_gaps && rows * cols > 1 && $urandom_range(6) == 0)
                n += $urandom_range(rows * cols - 1, 1);
            load_cells(n, spread);
            random_items += n;
        end

        settle_block();
        if (count_expected.size() != 0)
            flag_error($sformatf("%0d counts never arrived", count_expected.size()));
        if (errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
